@@ src/fhpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fhpc_pkg;

    localparam int HDR_BYTES = 24;
    localparam int POS_W     = $clog2(HDR_BYTES);

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(HDR_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(20);
    localparam logic [POS_W-1:0] CRC_HI_POS = POS_W'(21);

    localparam logic [15:0] HDR_LEN_WORD = 16'(HDR_BYTES);
    localparam logic [7:0]  HDR_LEN_BYTE = 8'(HDR_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] CFG_MAGIC   = 8'd0;
    localparam logic [7:0] CFG_VERSION = 8'd1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_MAGIC,
        ST_VERSION,
        ST_HDR_LEN,
        ST_TOTAL,
        ST_BUFFER,
        ST_CRC
    } status_t;

    typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_t;

    typedef struct packed {
        logic short_len;
        logic hdr_done;
    } parse_evt_t;

    typedef struct packed {
        logic [15:0] reserved_word;
        logic [15:0] header_check;
        logic [15:0] payload_length;
        logic [15:0] peer_status;
        logic [15:0] flag_bits;
        logic [7:0]  op_code;
        logic [7:0]  message_type;
        logic [7:0]  channel_id;
        logic [7:0]  channel_type;
        logic [15:0] ref_seq_number;
        logic [15:0] seq_number;
    } hdr_fields_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic logic [15:0] le_word(input hdr_bytes_t hdr, input int off);
        return {hdr[off + 1], hdr[off]};
    endfunction

endpackage

`default_nettype wire

@@ src/frame_header_parse_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial frame header checker. One byte is taken per cycle on the s_ side; s_tuser marks
// the first byte of a frame and samples the buffer length from s_tdata. The 24-byte
// little-endian header is captured and run through CRC-16 (0x1021, init 0xFFFF) with the CRC
// bytes fed as zero. The transfer carrying the last header byte, or a start byte whose buffer
// length is below 24, produces one result in the m_ output register. Input is taken at one
// byte per cycle; s_tready drops only while a result is held and m_tready is low. Bytes after
// the header are dropped until the next start. The user must write magic_word (index 0) and
// protocol_version (index 1) through the cfg_ port while idle; the block does not enforce it.
module frame_header_parse_check
    import fhpc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // rx_byte[7:0], buffer_length[23:8]
    input  wire logic         s_tuser,   // frame_start

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // seq_number, ref_seq_number, channel_type, channel_id, message_type, op_code,
    // flag_bits, peer_status, payload_length, header_check, reserved_word
    output logic [143:0]      m_tdata,
    output logic [2:0]        m_tuser,   // frame_status

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata
);

    logic        accept;
    parse_evt_t  evt;
    hdr_bytes_t  hdr_view;
    logic [15:0] crc_value;
    logic [15:0] saved_length;
    status_t     status;
    hdr_fields_t fields;

    logic [15:0] magic_reg;
    logic [7:0]  version_reg;

    logic         m_valid_reg, m_valid_next;
    hdr_fields_t  m_fields_reg;
    status_t      m_status_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= '0;
            version_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_MAGIC:   magic_reg   <= cfg_wdata;
                CFG_VERSION: version_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    fhpc_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .rx_byte       (s_tdata[7:0]),
        .frame_start   (s_tuser),
        .buffer_length (s_tdata[23:8]),
        .evt           (evt),
        .hdr_view      (hdr_view),
        .crc_value     (crc_value),
        .saved_length  (saved_length)
    );

    fhpc_check u_check (
        .evt              (evt),
        .hdr_view         (hdr_view),
        .crc_value        (crc_value),
        .saved_length     (saved_length),
        .magic_word       (magic_reg),
        .protocol_version (version_reg),
        .frame_status     (status),
        .fields           (fields)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (accept && (evt.short_len || evt.hdr_done)) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (evt.short_len || evt.hdr_done)) begin
            m_fields_reg <= fields;
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_fields_reg;
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

@@ src/fhpc_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fhpc_parser
    import fhpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    input  wire logic [15:0] buffer_length,
    output parse_evt_t       evt,
    output hdr_bytes_t       hdr_view,
    output logic [15:0]      crc_value,
    output logic [15:0]      saved_length
);

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [15:0]      crc_reg, crc_next, crc_eff, crc_upd;
    logic [15:0]      len_reg, len_next;
    logic             done_reg, done_next;
    logic             active;
    logic [7:0]       crc_in;
    logic [7:0]       store_reg [HDR_BYTES];

    always_comb begin
        pos_eff = frame_start ? '0 : pos_reg;
        crc_eff = frame_start ? CRC_INIT : crc_reg;
        active  = frame_start ? (buffer_length >= HDR_LEN_WORD) : !done_reg;

        evt.short_len = frame_start && (buffer_length < HDR_LEN_WORD);
        evt.hdr_done  = active && (pos_eff == LAST_POS);

        // CRC field bytes enter the check as zero
        crc_in  = (pos_eff == CRC_LO_POS || pos_eff == CRC_HI_POS) ? 8'h00 : rx_byte;
        crc_upd = crc16_byte(crc_eff, crc_in);

        pos_next  = pos_reg;
        crc_next  = crc_reg;
        len_next  = len_reg;
        done_next = done_reg;
        if (accept) begin
            if (frame_start) begin
                len_next = buffer_length;
            end
            pos_next  = pos_eff;
            crc_next  = crc_eff;
            done_next = !active;
            if (active) begin
                crc_next = crc_upd;
                if (pos_eff == LAST_POS) begin
                    done_next = 1'b1;
                    pos_next  = '0;
                end else begin
                    pos_next = pos_eff + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= CRC_INIT;
            len_reg  <= '0;
            done_reg <= 1'b1;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            len_reg  <= len_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && active && pos_eff <= LAST_POS) begin
            store_reg[pos_eff] <= rx_byte;
        end
    end

    // last header byte is taken straight from the input
    always_comb begin
        for (int i = 0; i < HDR_BYTES - 1; i++) begin
            hdr_view[i] = store_reg[i];
        end
        hdr_view[HDR_BYTES-1] = rx_byte;
    end

    assign crc_value    = crc_upd;
    assign saved_length = len_reg;

endmodule

`default_nettype wire

@@ src/fhpc_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fhpc_check
    import fhpc_pkg::*;
(
    input  wire parse_evt_t  evt,
    input  wire hdr_bytes_t  hdr_view,
    input  wire logic [15:0] crc_value,
    input  wire logic [15:0] saved_length,
    input  wire logic [15:0] magic_word,
    input  wire logic [7:0]  protocol_version,
    output status_t          frame_status,
    output hdr_fields_t      fields
);

    logic [15:0] frame_total;
    logic [15:0] pay_bytes;
    logic [15:0] expect_total;

    always_comb begin
        frame_total  = le_word(hdr_view, 4);
        pay_bytes    = le_word(hdr_view, 18);
        expect_total = HDR_LEN_WORD + pay_bytes;

        if (evt.short_len) begin
            frame_status = ST_SHORT;
        end else if (le_word(hdr_view, 0) != magic_word) begin
            frame_status = ST_MAGIC;
        end else if (hdr_view[2] != protocol_version) begin
            frame_status = ST_VERSION;
        end else if (hdr_view[3] != HDR_LEN_BYTE) begin
            frame_status = ST_HDR_LEN;
        end else if (frame_total != expect_total) begin
            frame_status = ST_TOTAL;
        end else if (frame_total > saved_length) begin
            frame_status = ST_BUFFER;
        end else if (crc_value != le_word(hdr_view, 20)) begin
            frame_status = ST_CRC;
        end else begin
            frame_status = ST_OK;
        end

        fields.seq_number     = le_word(hdr_view, 6);
        fields.ref_seq_number = le_word(hdr_view, 8);
        fields.channel_type   = hdr_view[10];
        fields.channel_id     = hdr_view[11];
        fields.message_type   = hdr_view[12];
        fields.op_code        = hdr_view[13];
        fields.flag_bits      = le_word(hdr_view, 14);
        fields.peer_status    = le_word(hdr_view, 16);
        fields.payload_length = pay_bytes;
        fields.header_check   = le_word(hdr_view, 20);
        fields.reserved_word  = le_word(hdr_view, 22);
        if (evt.short_len) begin
            fields = '0;
        end
    end

endmodule

`default_nettype wire

@@ tb/fhpc_result_check.sv @@
`timescale 1ns / 1ps

package fhpc_tb_pkg;
    import fhpc_pkg::*;

    // MSB-first CRC-16, one data bit per step
    function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc_in,
                                                     input logic [7:0]  data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ data[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction
endpackage

module fhpc_result_check
    import fhpc_pkg::*, fhpc_tb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [23:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output logic [7:0]   status_seen
);

    typedef struct packed {
        status_t     status;
        hdr_fields_t fields;
    } frame_result_t;

    frame_result_t expected_frames[$];

    logic [15:0]      magic_cfg;
    logic [7:0]       version_cfg;
    logic [POS_W-1:0] hdr_pos;
    logic [15:0]      hdr_crc;
    logic [7:0]       hdr_bytes [HDR_BYTES];
    logic [15:0]      buf_len;
    logic             parse_idle;

    function automatic logic [15:0] word_at(input int off);
        return {hdr_bytes[off + 1], hdr_bytes[off]};
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected 0x%h, got 0x%h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    task automatic track_header_byte(input logic [7:0] rx, input logic start,
                                     input logic [15:0] blen);
        frame_result_t r;
        logic [15:0]   total;
        logic [15:0]   payload;
        logic [15:0]   want_total;
        r = '0;
        if (start) begin
            hdr_pos    = '0;
            hdr_crc    = CRC_INIT;
            buf_len    = blen;
            parse_idle = 1'b0;
            if (blen < HDR_LEN_WORD) begin
                parse_idle = 1'b1;
                r.status   = ST_SHORT;
                expected_frames.push_back(r);
                return;
            end
        end
        if (parse_idle) return;

        hdr_bytes[hdr_pos] = rx;
        hdr_crc = crc_ccitt_update(hdr_crc,
                  (hdr_pos == CRC_LO_POS || hdr_pos == CRC_HI_POS) ? 8'h00 : rx);
        if (hdr_pos != LAST_POS) begin
            hdr_pos++;
            return;
        end

        parse_idle = 1'b1;
        hdr_pos    = '0;
        total      = word_at(4);
        payload    = word_at(18);
        want_total = payload + HDR_LEN_WORD;
        if (word_at(0) != magic_cfg)            r.status = ST_MAGIC;
        else if (hdr_bytes[2] != version_cfg)   r.status = ST_VERSION;
        else if (hdr_bytes[3] != HDR_LEN_BYTE)  r.status = ST_HDR_LEN;
        else if (total != want_total)           r.status = ST_TOTAL;
        else if (total > buf_len)               r.status = ST_BUFFER;
        else if (hdr_crc != word_at(20))        r.status = ST_CRC;
        else                                    r.status = ST_OK;

        r.fields.seq_number     = word_at(6);
        r.fields.ref_seq_number = word_at(8);
        r.fields.channel_type   = hdr_bytes[10];
        r.fields.channel_id     = hdr_bytes[11];
        r.fields.message_type   = hdr_bytes[12];
        r.fields.op_code        = hdr_bytes[13];
        r.fields.flag_bits      = word_at(14);
        r.fields.peer_status    = word_at(16);
        r.fields.payload_length = payload;
        r.fields.header_check   = word_at(20);
        r.fields.reserved_word  = word_at(22);
        expected_frames.push_back(r);
    endtask

    always @(posedge aclk) begin : watch
        frame_result_t want;
        hdr_fields_t   got;
        if (!aresetn) begin
            magic_cfg    = '0;
            version_cfg  = '0;
            hdr_pos      = '0;
            hdr_crc      = CRC_INIT;
            buf_len      = '0;
            parse_idle   = 1'b1;
            fail_count   = 0;
            results_seen = 0;
            status_seen  = '0;
            expected_frames.delete();
        end else begin
            // a result leaves only after its input is registered, so pop first
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                status_seen[m_tuser] = 1'b1;
                if (expected_frames.size() == 0) begin
                    $display("%0t: result transfer expected none, got status %0d",
                             $time, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_status", 16'(want.status), 16'(m_tuser));
                    check_field("seq_number", want.fields.seq_number, got.seq_number);
                    check_field("ref_seq_number", want.fields.ref_seq_number,
                                got.ref_seq_number);
                    check_field("channel_type", 16'(want.fields.channel_type),
                                16'(got.channel_type));
                    check_field("channel_id", 16'(want.fields.channel_id),
                                16'(got.channel_id));
                    check_field("message_type", 16'(want.fields.message_type),
                                16'(got.message_type));
                    check_field("op_code", 16'(want.fields.op_code), 16'(got.op_code));
                    check_field("flag_bits", want.fields.flag_bits, got.flag_bits);
                    check_field("peer_status", want.fields.peer_status, got.peer_status);
                    check_field("payload_length", want.fields.payload_length,
                                got.payload_length);
                    check_field("header_check", want.fields.header_check,
                                got.header_check);
                    check_field("reserved_word", want.fields.reserved_word,
                                got.reserved_word);
                end
            end
            if (s_tvalid && s_tready) begin
                track_header_byte(s_tdata[7:0], s_tuser, s_tdata[23:8]);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_MAGIC:   magic_cfg   = cfg_wdata;
                    CFG_VERSION: version_cfg = cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        pending <= expected_frames.size();
    end

endmodule

@@ tb/frame_header_parse_check_tb.sv @@
`timescale 1ns / 1ps

module frame_header_parse_check_tb;
    import fhpc_pkg::*;
    import fhpc_tb_pkg::*;

    localparam int         ITEM_TARGET = 1850;
    localparam int         PHASES      = 5;
    localparam int         LONG_HOLD   = 300;
    localparam int         IDLE_LIMIT  = 3000;
    localparam logic [7:0] CFG_SPARE   = 8'd2;

    typedef enum int {
        FLT_NONE,
        FLT_MAGIC,
        FLT_VERSION,
        FLT_HDR_LEN,
        FLT_TOTAL,
        FLT_BUFFER,
        FLT_CRC
    } fault_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    int          fail_count;
    int          pending;
    int          results_seen;
    logic [7:0]  status_seen;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          steady      = 1'b0;
    bit          hold_req    = 1'b0;
    bit          hold_active = 1'b0;
    logic [15:0] magic_now;
    logic [7:0]  version_now;

    frame_header_parse_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    fhpc_result_check u_result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .status_seen  (status_seen)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("frame_header_parse_check regression: fail");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit may_fail(input fault_t fault, input fault_t check);
        return (fault == check) ||
               (fault != FLT_NONE && fault < check && $urandom_range(0, 1) == 1);
    endfunction

    // receiver: random ready runs and stalls, plus one long hold on request
    initial begin : sink
        int run;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready    <= 1'b0;
                hold_active  = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_active  = 1'b0;
                hold_req     = 1'b0;
            end else begin
                run = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 200)
                                                   : $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                run = pick_gap();
                if (run > 0) begin
                    m_tready <= 1'b0;
                    repeat (run) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start,
                             input logic [15:0] blen, input bit counted);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blen, b};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) bytes_sent++;
    endtask

    // checks before the fault pass, the fault fails, later checks fail at random
    task automatic send_frame(input fault_t fault, input int payload_pin, input bit tight);
        logic [7:0]  hdr [HDR_BYTES];
        logic [15:0] payload;
        logic [15:0] total;
        logic [15:0] blen;
        logic [15:0] lo;
        logic [15:0] crc;
        bit          bad_magic;
        bit          bad_version;
        bit          bad_len;
        bit          bad_total;
        bit          bad_buffer;
        bit          bad_crc;
        int          r;
        int          trail;
        bad_magic   = may_fail(fault, FLT_MAGIC);
        bad_version = may_fail(fault, FLT_VERSION);
        bad_len     = may_fail(fault, FLT_HDR_LEN);
        bad_total   = may_fail(fault, FLT_TOTAL);
        bad_buffer  = may_fail(fault, FLT_BUFFER);
        bad_crc     = may_fail(fault, FLT_CRC);

        if (payload_pin >= 0) begin
            payload = 16'(payload_pin);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70)      payload = 16'($urandom_range(1, 200));
            else if (r < 85) payload = 16'($urandom_range(201, 65511));
            else if (r < 93) payload = 16'h0000;
            else             payload = 16'($urandom_range(65512, 65535)); // total wraps
        end
        if (bad_buffer && (payload == 16'h0000 || payload > 16'd65511)) begin
            payload = 16'($urandom_range(1, 200));
        end
        total = payload + HDR_LEN_WORD;
        if (bad_total) total ^= 16'($urandom_range(1, 65535));

        if (bad_buffer && total > HDR_LEN_WORD) begin
            blen = 16'($urandom_range(HDR_BYTES, total - 1));
        end else begin
            lo = (total > HDR_LEN_WORD) ? total : HDR_LEN_WORD;
            if (tight)
                blen = lo;
            else if ($urandom_range(0, 99) < 70)
                blen = 16'($urandom_range(lo, (lo > 16'd65471) ? 65535 : lo + 64));
            else
                blen = 16'($urandom_range(lo, 65535));
        end

        {hdr[1], hdr[0]} = magic_now ^ (bad_magic ? 16'($urandom_range(1, 65535)) : 16'h0000);
        hdr[2] = version_now ^ (bad_version ? 8'($urandom_range(1, 255)) : 8'h00);
        hdr[3] = HDR_LEN_BYTE ^ (bad_len ? 8'($urandom_range(1, 255)) : 8'h00);
        {hdr[5], hdr[4]} = total;
        for (int i = 6; i < 18; i++) hdr[i] = 8'($urandom);
        {hdr[19], hdr[18]} = payload;
        {hdr[21], hdr[20]} = 16'h0000;
        {hdr[23], hdr[22]} = 16'($urandom);
        crc = CRC_INIT;
        for (int i = 0; i < HDR_BYTES; i++) crc = crc_ccitt_update(crc, hdr[i]);
        {hdr[21], hdr[20]} = crc ^ (bad_crc ? 16'($urandom_range(1, 65535)) : 16'h0000);

        send_byte(hdr[0], 1'b1, blen, 1'b1);
        for (int i = 1; i < HDR_BYTES; i++) send_byte(hdr[i], 1'b0, 16'($urandom), 1'b1);
        trail = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3);
        repeat (trail) send_byte(8'($urandom), 1'b0, 16'($urandom), 1'b0);
    endtask

    task automatic run_phase(input int quota);
        int     stop_at;
        int     r;
        int     n;
        fault_t fault;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at) begin
            steady = ($urandom_range(0, 99) < 20);
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_byte(8'($urandom), 1'b1, 16'($urandom_range(0, HDR_BYTES - 1)), 1'b1);
            end else if (r < 12) begin
                // truncated header, dropped by whatever start comes next
                n = $urandom_range(1, HDR_BYTES - 1);
                send_byte(8'($urandom), 1'b1, 16'($urandom_range(HDR_BYTES, 65535)), 1'b1);
                repeat (n - 1) send_byte(8'($urandom), 1'b0, 16'($urandom), 1'b1);
            end else begin
                fault = (r < 55) ? FLT_NONE : fault_t'($urandom_range(FLT_MAGIC, FLT_CRC));
                send_frame(fault, -1, 1'b0);
            end
        end
        steady = 1'b0;
        send_frame(FLT_NONE, -1, 1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] addr, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_config(input bit spare);
        write_reg(CFG_MAGIC, magic_now);
        write_reg(CFG_VERSION, {8'($urandom), version_now});
        if (spare) write_reg(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        magic_now   = '0;
        version_now = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values; stray bytes, short buffers, restart, exact-fit buffer
        send_byte(8'hFF, 1'b0, 16'hFFFF, 1'b0);
        send_byte(8'h00, 1'b0, 16'h0000, 1'b0);
        send_byte(8'hFF, 1'b1, 16'h0000, 1'b1);
        send_byte(8'h00, 1'b1, 16'(HDR_BYTES - 1), 1'b1);
        send_byte(8'hA5, 1'b1, HDR_LEN_WORD, 1'b1);
        send_byte(8'h5A, 1'b0, 16'hFFFF, 1'b1);
        send_frame(FLT_NONE, 0, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    magic_now   = 16'hFFFF;
                    version_now = 8'hFF;
                end
                2: begin
                    magic_now   = 16'h0000;
                    version_now = 8'h00;
                end
                default: begin
                    magic_now   = 16'($urandom);
                    version_now = 8'($urandom);
                end
            endcase
            apply_config(p == 1);
            if (p == 1) begin
                // output held off while input keeps coming
                hold_req = 1'b1;
                steady   = 1'b1;
                while (!hold_active) @(posedge aclk);
                repeat (4) begin
                    send_byte(8'($urandom), 1'b1, 16'($urandom_range(0, HDR_BYTES - 1)), 1'b1);
                end
                send_frame(FLT_NONE, -1, 1'b0);
                send_frame(FLT_CRC, -1, 1'b0);
                steady = 1'b0;
            end
            run_phase((ITEM_TARGET - bytes_sent) / (PHASES - p));
            drain();
        end

        $display("covered %0d header and start bytes, %0d results, %0d register settings",
                 bytes_sent, results_seen, PHASES + 1);
        $display("status codes seen %b, one long output hold with input backpressure",
                 status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("frame_header_parse_check regression: pass");
        end else begin
            $display("frame_header_parse_check regression: fail");
        end
        $finish;
    end

endmodule
